// File: hw/rtl/md5d_pkg.sv
// Shared types, constants and round tables for the MD5 digest block.
// No dependencies; used by md5d_round and md5_message_digest.
package md5d_pkg;

  typedef logic [31:0] word_t;
  typedef logic [3:0][31:0] chain_t;

  // Control from the byte sequencer to the round unit
  typedef struct packed {
    logic start;   // begin compressing the 16 buffered words
    logic reinit;  // load the initial chaining values
  } md5d_ctl_t;

  localparam int unsigned BufWords = 16;
  localparam int unsigned WordAw   = 4;

  // Initial chaining values A, B, C, D
  localparam chain_t ChainInit = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [7:0] PadByte = 8'h80;

  // Message word used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    logic [3:0] k;
    lo = r[3:0];
    unique case (r[5:4])
      2'd0:    k = lo;
      2'd1:    k = 4'(lo * 4'd5 + 4'd1);
      2'd2:    k = 4'(lo * 4'd3 + 4'd5);
      default: k = 4'(lo * 4'd7);
    endcase
    return k;
  endfunction

  // Left rotate amount for round r
  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'ha: s = 5'd16;
      4'hb: s = 5'd23;
      4'hc: s = 5'd6;
      4'hd: s = 5'd10;
      4'he: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Additive constant for round r (integer part of |sin(r+1)| * 2^32)
  function automatic word_t sine_const(input logic [5:0] r);
    word_t t;
    unique case (r)
      6'd0:  t = 32'hd76aa478;  6'd1:  t = 32'he8c7b756;
      6'd2:  t = 32'h242070db;  6'd3:  t = 32'hc1bdceee;
      6'd4:  t = 32'hf57c0faf;  6'd5:  t = 32'h4787c62a;
      6'd6:  t = 32'ha8304613;  6'd7:  t = 32'hfd469501;
      6'd8:  t = 32'h698098d8;  6'd9:  t = 32'h8b44f7af;
      6'd10: t = 32'hffff5bb1;  6'd11: t = 32'h895cd7be;
      6'd12: t = 32'h6b901122;  6'd13: t = 32'hfd987193;
      6'd14: t = 32'ha679438e;  6'd15: t = 32'h49b40821;
      6'd16: t = 32'hf61e2562;  6'd17: t = 32'hc040b340;
      6'd18: t = 32'h265e5a51;  6'd19: t = 32'he9b6c7aa;
      6'd20: t = 32'hd62f105d;  6'd21: t = 32'h02441453;
      6'd22: t = 32'hd8a1e681;  6'd23: t = 32'he7d3fbc8;
      6'd24: t = 32'h21e1cde6;  6'd25: t = 32'hc33707d6;
      6'd26: t = 32'hf4d50d87;  6'd27: t = 32'h455a14ed;
      6'd28: t = 32'ha9e3e905;  6'd29: t = 32'hfcefa3f8;
      6'd30: t = 32'h676f02d9;  6'd31: t = 32'h8d2a4c8a;
      6'd32: t = 32'hfffa3942;  6'd33: t = 32'h8771f681;
      6'd34: t = 32'h6d9d6122;  6'd35: t = 32'hfde5380c;
      6'd36: t = 32'ha4beea44;  6'd37: t = 32'h4bdecfa9;
      6'd38: t = 32'hf6bb4b60;  6'd39: t = 32'hbebfbc70;
      6'd40: t = 32'h289b7ec6;  6'd41: t = 32'heaa127fa;
      6'd42: t = 32'hd4ef3085;  6'd43: t = 32'h04881d05;
      6'd44: t = 32'hd9d4d039;  6'd45: t = 32'he6db99e5;
      6'd46: t = 32'h1fa27cf8;  6'd47: t = 32'hc4ac5665;
      6'd48: t = 32'hf4292244;  6'd49: t = 32'h432aff97;
      6'd50: t = 32'hab9423a7;  6'd51: t = 32'hfc93a039;
      6'd52: t = 32'h655b59c3;  6'd53: t = 32'h8f0ccc92;
      6'd54: t = 32'hffeff47d;  6'd55: t = 32'h85845dd1;
      6'd56: t = 32'h6fa87e4f;  6'd57: t = 32'hfe2ce6e0;
      6'd58: t = 32'ha3014314;  6'd59: t = 32'h4e0811a1;
      6'd60: t = 32'hf7537e82;  6'd61: t = 32'hbd3af235;
      6'd62: t = 32'h2ad7d2bb;  default: t = 32'heb86d391;
    endcase
    return t;
  endfunction

endpackage

// File: hw/rtl/md5d_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module md5d_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/md5d_round.sv
// MD5 compression unit: one shared round datapath stepped 64 times per block,
// plus the chaining words. Depends on md5d_pkg; reads the block buffer RAM.
module md5d_round (
  input  logic                           clk,
  input  logic                           rst_n,
  input  md5d_pkg::md5d_ctl_t            ctl,
  output logic [md5d_pkg::WordAw-1:0]    raddr,
  input  md5d_pkg::word_t                rdata,
  output md5d_pkg::chain_t               chain,
  output logic                           done
);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_PRE  = 2'd1;
  localparam logic [1:0] R_RUN  = 2'd2;
  localparam logic [1:0] R_FOLD = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [5:0]       rnd_r, rnd_nxt;
  md5d_pkg::word_t  a_r, b_r, c_r, d_r, pre_r;
  md5d_pkg::word_t  a_nxt, b_nxt, c_nxt, d_nxt, pre_nxt;
  md5d_pkg::chain_t chain_r, chain_nxt;

  logic [5:0]       rnd_p1, rnd_p2;
  md5d_pkg::word_t  f_val, sum, rot;
  logic [63:0]      dbl;

  assign rnd_p1 = rnd_r + 6'd1;
  assign rnd_p2 = rnd_r + 6'd2;

  // Round function, selected by quarter
  always_comb begin
    case (rnd_r[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (d_r & b_r) | (~d_r & c_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  // pre_r already holds a + K[r] + W[k]
  assign sum = pre_r + f_val;
  assign dbl = {sum, sum} << md5d_pkg::rot_amount(rnd_r);
  assign rot = dbl[63:32];

  // Read one round ahead so the next pre-sum sees its message word
  always_comb begin
    unique case (state_r)
      R_PRE:   raddr = md5d_pkg::msg_index(6'd1);
      R_RUN:   raddr = md5d_pkg::msg_index(rnd_p2);
      default: raddr = '0;
    endcase
  end

  // Sequencer and datapath next state
  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    pre_nxt   = pre_r;
    chain_nxt = chain_r;
    done      = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (ctl.start) begin
          state_nxt = R_PRE;
        end
      end
      R_PRE: begin
        a_nxt     = chain_r[0];
        b_nxt     = chain_r[1];
        c_nxt     = chain_r[2];
        d_nxt     = chain_r[3];
        pre_nxt   = chain_r[0] + md5d_pkg::sine_const(6'd0) + rdata;
        rnd_nxt   = '0;
        state_nxt = R_RUN;
      end
      R_RUN: begin
        a_nxt   = d_r;
        d_nxt   = c_r;
        c_nxt   = b_r;
        b_nxt   = b_r + rot;
        pre_nxt = d_r + md5d_pkg::sine_const(rnd_p1) + rdata;
        rnd_nxt = rnd_p1;
        if (rnd_r == 6'd63) begin
          state_nxt = R_FOLD;
        end
      end
      default: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        done         = 1'b1;
        state_nxt    = R_IDLE;
      end
    endcase
    if (ctl.reinit) begin
      chain_nxt = md5d_pkg::ChainInit;
    end
  end

  // Control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
      rnd_r   <= '0;
      chain_r <= md5d_pkg::ChainInit;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      chain_r <= chain_nxt;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    pre_r <= pre_nxt;
  end

  assign chain = chain_r;

endmodule

// File: hw/rtl/md5_message_digest.sv
// MD5 digest top level: byte intake, padding sequencer and digest output.
// Depends on md5d_pkg, md5d_ram and md5d_round.

// Computes the MD5 digest of a byte stream. Each input transaction carries at
// most one message byte (in_tuser high) and may end the message (in_tlast).
// Bytes are taken one per cycle until a 64-byte block is full; the block is
// then compressed by a single round unit that does one MD5 round per cycle,
// and in_tready stays low while it runs (start, pre-sum, 64 rounds, chaining
// add). At the end of a message the sequencer writes padding words, one per
// cycle outside the compressions and up to 16 per block, and runs one or two
// more compressions, then presents the digest as four output transactions,
// word A first, with out_tlast on word D. The block accepts no input until
// the last digest word has been taken, and then starts afresh.
module md5_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast   // last_word
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CSTART = 3'd1;
  localparam logic [2:0] ST_CWAIT  = 3'd2;
  localparam logic [2:0] ST_PAD1   = 3'd3;
  localparam logic [2:0] ST_PADZ   = 3'd4;
  localparam logic [2:0] ST_PADL   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // What follows a compression
  localparam logic [1:0] POST_IDLE = 2'd0;
  localparam logic [1:0] POST_PAD  = 2'd1;
  localparam logic [1:0] POST_ZERO = 2'd2;
  localparam logic [1:0] POST_OUT  = 2'd3;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [3:0]  wcnt_r, wcnt_nxt;
  logic        len_blk_r, len_blk_nxt;
  logic [1:0]  post_r, post_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  logic [31:0] word_buf_r, word_buf_nxt;

  logic                        in_acc, out_acc;
  logic                        ram_we;
  logic [md5d_pkg::WordAw-1:0] ram_waddr, ram_raddr;
  md5d_pkg::word_t             ram_wdata, ram_rdata;
  md5d_pkg::md5d_ctl_t         ctl;
  md5d_pkg::chain_t            chain;
  logic                        cmp_done;
  md5d_pkg::word_t             pad_word;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_acc   = out_tvalid & out_tready;

  // First padding word: kept bytes, 0x80 marker, zeros above
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (2'(j) < fill_r[1:0]) begin
        pad_word[8*j +: 8] = word_buf_r[8*j +: 8];
      end else if (2'(j) == fill_r[1:0]) begin
        pad_word[8*j +: 8] = md5d_pkg::PadByte;
      end else begin
        pad_word[8*j +: 8] = 8'h00;
      end
    end
  end

  // Main sequencer
  always_comb begin
    state_nxt    = state_r;
    fill_nxt     = fill_r;
    bits_nxt     = bits_r;
    wcnt_nxt     = wcnt_r;
    len_blk_nxt  = len_blk_r;
    post_nxt     = post_r;
    oidx_nxt     = oidx_r;
    word_buf_nxt = word_buf_r;
    ram_we       = 1'b0;
    ram_waddr    = fill_r[5:2];
    ram_wdata    = {in_tdata, word_buf_r[23:0]};
    ctl          = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            word_buf_nxt[8*fill_r[1:0] +: 8] = in_tdata;
            fill_nxt = fill_r + 6'd1;
            bits_nxt = bits_r + 64'd8;
            ram_we   = (fill_r[1:0] == 2'd3);
          end
          if (in_tuser && fill_r == 6'd63) begin
            state_nxt = ST_CSTART;
            post_nxt  = in_tlast ? POST_PAD : POST_IDLE;
          end else if (in_tlast) begin
            state_nxt = ST_PAD1;
          end
        end
      end
      ST_PAD1: begin
        ram_we    = 1'b1;
        ram_wdata = pad_word;
        case (fill_r[5:2])
          4'd15: begin
            state_nxt = ST_CSTART;
            post_nxt  = POST_ZERO;
          end
          4'd14: begin
            state_nxt   = ST_PADZ;
            wcnt_nxt    = 4'd15;
            len_blk_nxt = 1'b0;
          end
          4'd13: begin
            state_nxt = ST_PADL;
            wcnt_nxt  = 4'd14;
          end
          default: begin
            state_nxt   = ST_PADZ;
            wcnt_nxt    = fill_r[5:2] + 4'd1;
            len_blk_nxt = 1'b1;
          end
        endcase
      end
      ST_PADZ: begin
        ram_we    = 1'b1;
        ram_waddr = wcnt_r;
        ram_wdata = '0;
        if (len_blk_r && wcnt_r == 4'd13) begin
          state_nxt = ST_PADL;
          wcnt_nxt  = 4'd14;
        end else if (!len_blk_r && wcnt_r == 4'd15) begin
          state_nxt = ST_CSTART;
          post_nxt  = POST_ZERO;
        end else begin
          wcnt_nxt = wcnt_r + 4'd1;
        end
      end
      ST_PADL: begin
        // Bit length, low word first
        ram_we    = 1'b1;
        ram_waddr = wcnt_r;
        ram_wdata = wcnt_r[0] ? bits_r[63:32] : bits_r[31:0];
        if (wcnt_r == 4'd15) begin
          state_nxt = ST_CSTART;
          post_nxt  = POST_OUT;
        end else begin
          wcnt_nxt = 4'd15;
        end
      end
      ST_CSTART: begin
        ctl.start = 1'b1;
        state_nxt = ST_CWAIT;
      end
      ST_CWAIT: begin
        if (cmp_done) begin
          case (post_r)
            POST_IDLE: state_nxt = ST_IDLE;
            POST_PAD:  state_nxt = ST_PAD1;
            POST_ZERO: begin
              state_nxt   = ST_PADZ;
              wcnt_nxt    = 4'd0;
              len_blk_nxt = 1'b1;
            end
            default: begin
              state_nxt = ST_OUT;
              oidx_nxt  = 2'd0;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (out_acc) begin
          oidx_nxt = oidx_r + 2'd1;
          if (oidx_r == 2'd3) begin
            ctl.reinit = 1'b1;
            fill_nxt   = '0;
            bits_nxt   = '0;
            state_nxt  = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      bits_r    <= '0;
      wcnt_r    <= '0;
      len_blk_r <= 1'b0;
      post_r    <= POST_IDLE;
      oidx_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      fill_r    <= fill_nxt;
      bits_r    <= bits_nxt;
      wcnt_r    <= wcnt_nxt;
      len_blk_r <= len_blk_nxt;
      post_r    <= post_nxt;
      oidx_r    <= oidx_nxt;
    end
  end

  // Partial word under assembly
  always_ff @(posedge clk) begin
    word_buf_r <= word_buf_nxt;
  end

  // Block buffer, one 32-bit little-endian word per entry
  md5d_ram #(
    .WIDTH(32),
    .DEPTH(md5d_pkg::BufWords)
  ) u_buf (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  md5d_round u_round (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (ctl),
    .raddr(ram_raddr),
    .rdata(ram_rdata),
    .chain(chain),
    .done (cmp_done)
  );

  // Digest output
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = chain[oidx_r];
  assign out_tuser  = oidx_r;
  assign out_tlast  = (oidx_r == 2'd3);

endmodule

// File: sim/tb.sv
// Testbench for md5_message_digest: byte-stream driver, digest-word monitor and an MD5
// predictor that runs on every accepted input transaction.
// Depends only on the RTL under hw/rtl.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldCycles = 400;   // long receiver hold-off
  localparam int unsigned StallLimit = 3000;  // cycles with no transaction at all
  localparam int unsigned TailCycles = 150;
  localparam int unsigned RandItems  = 330;

  typedef struct {
    bit [7:0] data;
    bit       has_byte;
    bit       eom;
    bit [1:0] phase;
    bit       wait_idle;  // offer only once every digest word has come back
    bit       hold_out;   // receiver holds off after this transaction
  } byte_item_t;

  typedef struct {
    bit [31:0] word;
    bit [1:0]  index;
    bit        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] has_byte
  logic        in_tlast = 1'b0;    // end_of_message
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] digest_word
  logic [1:0]  out_tuser;          // [1:0] word_index
  logic        out_tlast;          // last_word

  md5_message_digest u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_item_t   byte_q[$];
  digest_word_t digest_q[$];
  int unsigned  err_cnt = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  holds_req = 0;
  int unsigned  holds_done = 0;
  int unsigned  hold_left = 0;
  bit           in_taken = 1'b0;
  bit [1:0]     cur_phase = 2'd0;

  // ---------------------------------------------------------------------------
  // MD5 predictor
  // ---------------------------------------------------------------------------
  bit [31:0] md5_chain[4];
  bit [7:0]  blk_bytes[64];
  int        blk_fill;
  bit [63:0] msg_len_bits;

  bit [31:0] sine_tab[64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

  // shift amounts, indexed by {round quarter, round mod 4}
  int unsigned rot_tab[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  function automatic void md5_init();
    md5_chain[0] = 32'h67452301;
    md5_chain[1] = 32'hefcdab89;
    md5_chain[2] = 32'h98badcfe;
    md5_chain[3] = 32'h10325476;
    blk_fill = 0;
    msg_len_bits = 64'd0;
  endfunction

  function automatic void md5_compress();
    bit [31:0]   m[16];
    bit [31:0]   a, b, c, d, f, t, sum;
    int unsigned k, s;
    for (int i = 0; i < 16; i++)
      m[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
    a = md5_chain[0];
    b = md5_chain[1];
    c = md5_chain[2];
    d = md5_chain[3];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        f = (b & c) | (~b & d);
        k = r;
      end else if (r < 32) begin
        f = (d & b) | (~d & c);
        k = (5 * r + 1) % 16;
      end else if (r < 48) begin
        f = b ^ c ^ d;
        k = (3 * r + 5) % 16;
      end else begin
        f = c ^ (b | ~d);
        k = (7 * r) % 16;
      end
      s = rot_tab[(r / 16) * 4 + (r % 4)];
      sum = a + f + sine_tab[r] + m[k];
      t = d;
      d = c;
      c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
      a = t;
    end
    md5_chain[0] += a;
    md5_chain[1] += b;
    md5_chain[2] += c;
    md5_chain[3] += d;
  endfunction

  // Absorb one accepted transaction; queue the digest words a message end produces
  function automatic void md5_absorb(byte_item_t it);
    bit [63:0]    total;
    digest_word_t dw;
    if (it.has_byte) begin
      blk_bytes[blk_fill] = it.data;
      blk_fill++;
      msg_len_bits += 64'd8;
      if (blk_fill == 64) begin
        md5_compress();
        blk_fill = 0;
      end
    end
    if (it.eom) begin
      total = msg_len_bits;
      blk_bytes[blk_fill] = 8'h80;
      blk_fill++;
      // no room for the length: pad out and compress an extra block
      if (blk_fill > 56) begin
        while (blk_fill < 64) begin
          blk_bytes[blk_fill] = 8'h00;
          blk_fill++;
        end
        md5_compress();
        blk_fill = 0;
      end
      while (blk_fill < 56) begin
        blk_bytes[blk_fill] = 8'h00;
        blk_fill++;
      end
      for (int i = 0; i < 8; i++)
        blk_bytes[56+i] = total[8*i +: 8];
      md5_compress();
      for (int i = 0; i < 4; i++) begin
        dw.word  = md5_chain[i];
        dw.index = 2'(i);
        dw.last  = (i == 3);
        digest_q.push_back(dw);
      end
      md5_init();
    end
  endfunction

  function automatic int unsigned sender_idle_pct(bit [1:0] ph);
    return (ph == 2'd0) ? 29 : (ph == 2'd1) ? 80 : 0;
  endfunction

  function automatic int unsigned receiver_idle_pct(bit [1:0] ph);
    return (ph == 2'd0) ? 80 : (ph == 2'd1) ? 29 : 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: sample at rising edge, drive at falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      md5_absorb(byte_q[0]);
      if (byte_q[0].hold_out)
        holds_req++;
      void'(byte_q.pop_front());
      in_taken <= 1'b1;
    end else begin
      in_taken <= 1'b0;
    end
  end

  always @(negedge clk) begin
    bit offer;
    offer = 1'b0;
    if (rst_n) begin
      if (in_tvalid && !in_taken) begin
        offer = 1'b1;  // still waiting for in_tready
      end else if (byte_q.size() != 0) begin
        if (!(byte_q[0].wait_idle && digest_q.size() != 0))
          offer = ($urandom_range(99) >= sender_idle_pct(byte_q[0].phase));
      end
    end
    in_tvalid <= offer;
    if (offer) begin
      in_tdata  <= byte_q[0].data;
      in_tuser  <= byte_q[0].has_byte;
      in_tlast  <= byte_q[0].eom;
      cur_phase <= byte_q[0].phase;
    end
  end

  // ---------------------------------------------------------------------------
  // Digest monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected digest transaction: expected none, actual word %h idx %0d last %0b",
                 $realtime, out_tdata, out_tuser, out_tlast);
      end else begin
        exp_w = digest_q.pop_front();
        if (out_tdata !== exp_w.word || out_tuser !== exp_w.index || out_tlast !== exp_w.last) begin
          err_cnt++;
          $display("%0t: digest mismatch: expected word %h idx %0d last %0b, actual word %h idx %0d last %0b",
                   $realtime, exp_w.word, exp_w.index, exp_w.last, out_tdata, out_tuser, out_tlast);
        end
      end
    end
  end

  always @(negedge clk) begin
    bit rdy;
    rdy = 1'b0;
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left--;
      end else if (holds_done != holds_req) begin
        holds_done++;
        hold_left = HoldCycles;
      end else begin
        rdy = ($urandom_range(99) >= receiver_idle_pct(cur_phase));
      end
    end
    out_tready <= rdy;
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no transaction on either side for too long
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  bit [1:0]    gen_phase = 2'd0;
  int unsigned counted = 0;

  task automatic push_item(bit [7:0] data, bit has, bit eom, bit wait_idle = 1'b0,
                           bit hold_out = 1'b0);
    byte_item_t it;
    it.data      = data;
    it.has_byte  = has;
    it.eom       = eom;
    it.phase     = gen_phase;
    it.wait_idle = wait_idle;
    it.hold_out  = hold_out;
    byte_q.push_back(it);
  endtask

  // One message of len random bytes, with some empty transactions mixed in
  task automatic push_message(int unsigned len, bit wait_first, bit hold_end);
    bit sep_end;
    bit first;
    sep_end = (len == 0) || ($urandom_range(1) == 1);
    first = wait_first;
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        push_item(8'($urandom), 1'b0, 1'b0);
        counted++;
      end
      push_item(8'($urandom), 1'b1, (i == len - 1) && !sep_end, first,
                (i == len - 1) && !sep_end && hold_end);
      first = 1'b0;
      counted++;
    end
    if (sep_end) begin
      // end without a byte; data is ignored
      push_item(8'($urandom), 1'b0, 1'b1, first, hold_end);
      counted++;
    end
  endtask

  initial begin
    int unsigned len, pick, msgs;
    bit          did_wait, did_hold;
    int unsigned boundary[8] = '{55, 56, 57, 63, 64, 65, 119, 120};
    md5_init();
    for (int i = 0; i < 64; i++)
      blk_bytes[i] = 8'h00;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part
    push_item(8'hff, 1'b0, 1'b0);   // empty transactions change nothing
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);   // empty message
    push_item(8'hff, 1'b0, 1'b1);   // another empty message right behind
    push_item(8'h61, 1'b1, 1'b0);   // "abc"
    push_item(8'h62, 1'b1, 1'b0);
    push_item(8'h63, 1'b1, 1'b1);
    push_item(8'hff, 1'b1, 1'b1);   // single all-ones byte
    push_item(8'h00, 1'b1, 1'b0);   // zero byte, then end without byte
    push_item(8'ha5, 1'b0, 1'b1);

    // Random messages; boundary lengths hit the full-block and extra-pad-block cases
    msgs = 0;
    did_wait = 1'b0;
    did_hold = 1'b0;
    while (counted < RandItems || msgs < 12) begin
      gen_phase = (counted < RandItems / 3) ? 2'd0 : (counted < 2 * RandItems / 3) ? 2'd1 : 2'd2;
      pick = $urandom_range(9);
      if (pick < 7)
        len = $urandom_range(12);
      else if (pick < 9)
        len = boundary[$urandom_range(7)];
      else
        len = $urandom_range(130);
      push_message(len, (gen_phase == 2'd1) && !did_wait, (gen_phase == 2'd2) && !did_hold);
      if (gen_phase == 2'd1)
        did_wait = 1'b1;
      if (gen_phase == 2'd2)
        did_hold = 1'b1;
      msgs++;
    end

    while (byte_q.size() != 0)
      @(posedge clk);
    while (digest_q.size() != 0)
      @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
